// ----- rtl/rhh_pkg.sv -----
// shared types and constants for the robin hood hash table
`default_nettype none
package rhh_pkg;
   localparam int unsigned DefaultTableSlots = 256;
   localparam int unsigned DefaultValueBits = 32;
   localparam int unsigned KeyBits = 64;
   localparam int unsigned FieldValueBits = 32;
   localparam int unsigned MaxIndexBits = 16;
   localparam logic [63:0] GoldenMult = 64'd11400714819323198485;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic done;
      logic [MaxIndexBits-1:0] slot;
   } hash_rsp_type;
endpackage
`default_nettype wire

// ----- rtl/rhh_if.sv -----
// request and response channel interfaces
`default_nettype none
interface rhh_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [63:0] key;
   logic [31:0] value;
   modport source (output valid, op, key, value, input ready);
   modport sink (input valid, op, key, value, output ready);
endinterface

interface rhh_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [31:0] found_value;
   modport source (output valid, status, found_value, input ready);
   modport sink (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/rhh_hash.sv -----
// fibonacci hash unit on one shared 32x32 multiplier; a new start abandons any key in progress
`default_nettype none
module rhh_hash #(
   parameter int unsigned IndexBits = 8
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [63:0] key,
   output rhh_pkg::hash_rsp_type hash_rsp
);
   localparam int unsigned Shift = 64 - IndexBits;

   logic [63:0] fold_ff, fold_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [31:0] mul_a, mul_b;

   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = fold_ff[31:0];
            mul_b = rhh_pkg::GoldenMult[31:0];
         end
         2'd1: begin
            mul_a = fold_ff[31:0];
            mul_b = rhh_pkg::GoldenMult[63:32];
         end
         default: begin
            mul_a = fold_ff[63:32];
            mul_b = rhh_pkg::GoldenMult[31:0];
         end
      endcase
   end

   always_comb begin
      fold_in = fold_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         fold_in = key ^ (key >> Shift);
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {32'd0, mul_a} * {32'd0, mul_b};
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            default: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         endcase
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign hash_rsp.done = done_ff;
   assign hash_rsp.slot = rhh_pkg::MaxIndexBits'(acc_ff[63:Shift]);
endmodule
`default_nettype wire

// ----- rtl/rhh_slot_mem.sv -----
// slot key and value memory, one write and one registered read
`default_nettype none
module rhh_slot_mem #(
   parameter int unsigned TableSlots = 256,
   parameter int unsigned ValueBits = 32,
   localparam int unsigned IndexBits = $clog2(TableSlots)
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [IndexBits-1:0] wr_idx,
   input wire logic [63:0] wr_key,
   input wire logic [ValueBits-1:0] wr_val,
   input wire logic rd_en,
   input wire logic [IndexBits-1:0] rd_idx,
   output logic [63:0] rd_key,
   output logic [ValueBits-1:0] rd_val
);
   logic [63:0] key_mem [TableSlots];
   logic [ValueBits-1:0] val_mem [TableSlots];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_idx] <= wr_key;
         val_mem[wr_idx] <= wr_val;
      end
      if (rd_en) begin
         rd_key <= key_mem[rd_idx];
         rd_val <= val_mem[rd_idx];
      end
   end
endmodule
`default_nettype wire

// ----- rtl/robin_hood_hash_table_core.sv -----
// robin hood hash table top level: sequencer, occupancy flags and result register
//
// channel   dir  handshake               payload
// req_chan  in   valid/ready             op, key, value
// rsp_chan  out  valid/ready             status, found_value
//
// one item at a time; hashing runs on the shared multiplier
// each lookup probe is a memory read, then a compare
// each insert probe is a memory read, then a check, plus hashing a resident key
// a result waits in the output register; the next item is taken once it is loaded
// reset clears occupancy flags, item count and handshake state
`default_nettype none
module robin_hood_hash_table_core #(
   parameter int unsigned TABLE_SLOTS = rhh_pkg::DefaultTableSlots,
   parameter int unsigned VALUE_BITS = rhh_pkg::DefaultValueBits
) (
   input wire logic clock,
   input wire logic reset,
   rhh_req_if.sink req_chan,
   rhh_rsp_if.source rsp_chan
);
   localparam int unsigned IB = $clog2(TABLE_SLOTS);
   localparam logic [IB:0] Slots = (IB+1)'(TABLE_SLOTS);
   localparam logic [IB:0] LastProbe = (IB+1)'(TABLE_SLOTS - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HASH = 3'd1;
   localparam logic [2:0] S_FRD = 3'd2;
   localparam logic [2:0] S_FCHK = 3'd3;
   localparam logic [2:0] S_PRD = 3'd4;
   localparam logic [2:0] S_PCHK = 3'd5;
   localparam logic [2:0] S_PHASH = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic op_ff, op_in;
   logic [63:0] key_ff, key_in;            // key being searched or carried
   logic [VALUE_BITS-1:0] val_ff, val_in;  // value carried along the probe
   logic [IB-1:0] idx_ff, idx_in;
   logic [IB-1:0] home_ff, home_in;
   logic [IB:0] cnt_ff, cnt_in;            // probe count or probe distance
   logic [IB:0] count_ff, count_in;        // stored item count
   logic [TABLE_SLOTS-1:0] occ_ff;
   logic occ_rd_ff, occ_rd_in;
   logic occ_set;
   logic [1:0] res_status_ff, res_status_in;
   logic [31:0] res_value_ff, res_value_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_value_ff, rsp_value_in;

   logic hash_start;
   logic [63:0] hash_key;
   rhh_pkg::hash_rsp_type hash_rsp;
   logic [IB-1:0] hash_slot;
   logic [IB-1:0] rdist;

   logic mem_wr_en, mem_rd_en;
   logic [63:0] rd_key;
   logic [VALUE_BITS-1:0] rd_val;

   logic req_fire;

   rhh_hash #(.IndexBits(IB)) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .key(hash_key),
      .hash_rsp(hash_rsp)
   );

   rhh_slot_mem #(.TableSlots(TABLE_SLOTS), .ValueBits(VALUE_BITS)) u_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_idx(idx_ff),
      .wr_key(key_ff),
      .wr_val(val_ff),
      .rd_en(mem_rd_en),
      .rd_idx(idx_ff),
      .rd_key(rd_key),
      .rd_val(rd_val)
   );

   assign hash_slot = hash_rsp.slot[IB-1:0];
   // distance of the resident from its own home slot
   assign rdist = idx_ff - hash_slot;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      home_in = home_ff;
      cnt_in = cnt_ff;
      count_in = count_ff;
      occ_rd_in = occ_rd_ff;
      occ_set = 1'b0;
      res_status_in = res_status_ff;
      res_value_in = res_value_ff;
      hash_start = 1'b0;
      hash_key = key_ff;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in = req_chan.op;
               key_in = req_chan.key;
               val_in = VALUE_BITS'(req_chan.value);
               hash_start = 1'b1;
               hash_key = req_chan.key;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_rsp.done) begin
               idx_in = hash_slot;
               home_in = hash_slot;
               cnt_in = '0;
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            mem_rd_en = 1'b1;
            occ_rd_in = occ_ff[idx_ff];
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (occ_rd_ff && rd_key == key_ff) begin
               // key present
               res_status_in = (op_ff == rhh_pkg::OP_INSERT) ?
                               rhh_pkg::ST_DUPLICATE : rhh_pkg::ST_OK;
               res_value_in = (op_ff == rhh_pkg::OP_INSERT) ? 32'd0 : 32'(rd_val);
               state_in = S_DONE;
            end else if (occ_rd_ff && cnt_ff != LastProbe) begin
               idx_in = idx_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
               state_in = S_FRD;
            end else begin
               // empty slot met or every slot visited: key absent
               res_value_in = 32'd0;
               if (op_ff == rhh_pkg::OP_LOOKUP) begin
                  res_status_in = rhh_pkg::ST_NOT_FOUND;
                  state_in = S_DONE;
               end else if (count_ff >= Slots) begin
                  res_status_in = rhh_pkg::ST_FULL;
                  state_in = S_DONE;
               end else begin
                  idx_in = home_ff;
                  cnt_in = '0;
                  state_in = S_PRD;
               end
            end
         end
         S_PRD: begin
            mem_rd_en = 1'b1;
            occ_rd_in = occ_ff[idx_ff];
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (!occ_rd_ff) begin
               mem_wr_en = 1'b1;
               occ_set = 1'b1;
               count_in = count_ff + 1'b1;
               res_status_in = rhh_pkg::ST_OK;
               res_value_in = 32'd0;
               state_in = S_DONE;
            end else begin
               hash_start = 1'b1;
               hash_key = rd_key;
               state_in = S_PHASH;
            end
         end
         S_PHASH: begin
            if (hash_rsp.done) begin
               if ({1'b0, rdist} < cnt_ff) begin
                  // resident is richer: swap and carry it on
                  mem_wr_en = 1'b1;
                  key_in = rd_key;
                  val_in = rd_val;
                  cnt_in = {1'b0, rdist} + 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               state_in = S_PRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in = res_value_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      home_ff <= home_in;
      cnt_ff <= cnt_in;
      occ_rd_ff <= occ_rd_in;
      res_status_ff <= res_status_in;
      res_value_ff <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff <= rsp_value_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         occ_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (occ_set) begin
            occ_ff[idx_ff] <= 1'b1;
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.found_value = rsp_value_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Slots) else $error("item count above table size");
   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_HASH) else $error("accepted item did not start hashing");
   a_hash_done_expected: assert property (@(posedge clock) disable iff (reset)
      hash_rsp.done |-> (state_ff == S_HASH || state_ff == S_PHASH))
      else $error("hash result with no waiter");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(occ_set) && count_ff == $past(count_ff) + 1'b1)
      else $error("item count changed without a placement");
`endif
endmodule
`default_nettype wire
